// ===== sv/percent_encoder_bounded_macros.svh =====
// Assertion macros shared by the percent encoder RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef PERCENT_ENCODER_BOUNDED_MACROS_SVH
`define PERCENT_ENCODER_BOUNDED_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define PEB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PEB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pct_enc_pkg.sv =====
// Shared types, constants and helpers for the percent encoder.
// Used by the front end, queue, back end and top level; depends on nothing.
package pct_enc_pkg;

    localparam logic [7:0] PCT_MARK  = 8'h25;
    localparam logic [7:0] TERM_BYTE = 8'h00;
    localparam logic [3:0] NIB_MASK  = 4'hF;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // What the back end has to write for one source byte.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PASS,
        CMD_ESC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] src;
        logic       term;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Letters, digits and - _ . ~ go through unchanged.
    function automatic logic is_unreserved(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                         8'h2D, 8'h5F, 8'h2E, 8'h7E};
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return HEX_DIGITS[nib & NIB_MASK];
    endfunction

endpackage

// ===== sv/pct_enc_front.sv =====
// Front end of the percent encoder: accepts source bytes and classifies them.
// Holds the written count and the stop flag; depends on pct_enc_pkg.
module pct_enc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_message,
    input  logic [15:0]        out_capacity,
    input  logic               q_full,
    output logic               push,
    output pct_enc_pkg::cmd_t  push_cmd,
    output logic               stopped
);
    import pct_enc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic        stopped_reg, stopped_next;
    logic        accept;
    logic        ends;
    logic        halt;
    logic [15:0] limit;
    logic [15:0] count_new;
    logic [16:0] count_p3;
    cmd_kind_t   kind;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign stopped  = stopped_reg;
    assign ends     = end_of_message || (data_byte == 8'h00);
    assign limit    = (out_capacity == 16'd0) ? 16'd0 : out_capacity - 16'd1;
    assign count_p3 = {1'b0, count_reg} + 17'd3;

    // Classify the byte against the room left in the buffer.
    always_comb
    begin
        kind      = CMD_NONE;
        halt      = 1'b0;
        count_new = count_reg;
        if (data_byte != 8'h00)
        begin
            if (count_reg >= limit)
            begin
                halt = 1'b1;
            end
            else if (is_unreserved(data_byte))
            begin
                kind      = CMD_PASS;
                count_new = count_reg + 16'd1;
                halt      = (count_new >= limit);
            end
            else if (count_p3 < {1'b0, limit})
            begin
                kind      = CMD_ESC;
                count_new = count_p3[15:0];
                halt      = (count_new >= limit);
            end
            else
            begin
                halt = 1'b1;
            end
        end
    end

    // A stopped message yields nothing until its end rearms the block.
    assign push          = accept && !stopped_reg && ((kind != CMD_NONE) || ends || halt);
    assign push_cmd.kind = kind;
    assign push_cmd.src  = data_byte;
    assign push_cmd.term = ends || halt;

    // Next count and stop flag.
    always_comb
    begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (ends)
            begin
                count_next   = 16'd0;
                stopped_next = 1'b0;
            end
            else if (!stopped_reg)
            begin
                count_next   = count_new;
                stopped_next = halt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 16'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== sv/pct_enc_queue.sv =====
// Small first-in first-out queue of commands between front and back end.
// Register based, combinational head; depends on pct_enc_pkg.
module pct_enc_queue #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         head,
    output pct_enc_pkg::q_status_t   status
);
    import pct_enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_CNT);

    // Pointer wrap and fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/pct_enc_back.sv =====
// Back end of the percent encoder: expands queued commands into output beats.
// One output byte per cycle while out_stall is low, via a registered output; depends on pct_enc_pkg.
module pct_enc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pct_enc_pkg::cmd_t  head_cmd,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               out_last
);
    import pct_enc_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic [2:0] base;
    logic [2:0] total;
    logic       last_step;
    logic [7:0] byte_val;
    logic       last_val;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Load a new beat whenever the queue holds a command and the output register is free or draining.
    assign load = !q_empty && (!out_valid_reg || !out_stall);

    // Number of data beats this command produces, before any terminator.
    always_comb
    begin
        case (head_cmd.kind)
            CMD_PASS: base = 3'd1;
            CMD_ESC:  base = 3'd3;
            default:  base = 3'd0;
        endcase
    end

    assign total     = base + {2'b00, head_cmd.term};
    assign last_step = (({1'b0, phase_reg} + 3'd1) == total);
    assign pop       = load && last_step;

    // Beat contents for the current phase.
    always_comb
    begin
        byte_val = TERM_BYTE;
        last_val = 1'b1;
        if ({1'b0, phase_reg} < base)
        begin
            last_val = 1'b0;
            case (head_cmd.kind)
                CMD_PASS: byte_val = head_cmd.src;
                CMD_ESC:
                begin
                    case (phase_reg)
                        2'd0:    byte_val = PCT_MARK;
                        2'd1:    byte_val = hex_digit(head_cmd.src[7:4]);
                        default: byte_val = hex_digit(head_cmd.src[3:0]);
                    endcase
                end
                default: byte_val = TERM_BYTE;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            phase_next = last_step ? 2'd0 : phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= last_val;
        end
    end

endmodule

// ===== sv/percent_encoder_bounded.sv =====
// Top level of the bounded percent encoder: capacity register, front end,
// command queue and back end. Depends on pct_enc_pkg and the assertion macros.
//
// Source bytes enter one per beat and leave URL percent-encoded, one byte per
// output beat, followed by a zero terminator marked last when the message ends
// or the buffer of out_capacity bytes is full. The front end takes an input
// beat every cycle while its command queue (QUEUE_DEPTH entries) has room; the
// back end writes one output byte per cycle while out_stall is low, so a
// pass-through byte yields one output byte, an escaped byte three, and a
// terminator one more. Sustained throughput is therefore set by the single
// output byte register. Capacity is written through the cfg port.
`include "percent_encoder_bounded_macros.svh"

module percent_encoder_bounded #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] out_capacity,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);
    import pct_enc_pkg::*;

    localparam int CMD_W = $bits(cmd_t);

    logic [15:0]  capacity_reg;
    logic         q_push;
    logic         q_pop;
    cmd_t         push_cmd;
    cmd_t         head_cmd;
    logic [CMD_W-1:0] head_bits;
    q_status_t    q_stat;
    logic         stopped;

    // Capacity register; the user must write it only while the block is idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= out_capacity;
        end
    end

    pct_enc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_capacity   (capacity_reg),
        .q_full         (q_stat.full),
        .push           (q_push),
        .push_cmd       (push_cmd),
        .stopped        (stopped)
    );

    pct_enc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .head      (head_bits),
        .status    (q_stat)
    );

    assign head_cmd = cmd_t'(head_bits);

    pct_enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_empty   (q_stat.empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // A stopped message never queues work for the back end.
    `PEB_ASSERT(a_no_push_stopped, stopped |-> !q_push, "command queued while stopped")
    // The queue is never written when full nor read when empty.
    `PEB_ASSERT(a_queue_no_overflow, q_stat.full |-> !q_push, "queue overflow")
    `PEB_ASSERT(a_queue_no_underflow, q_stat.empty |-> !q_pop, "queue underflow")
    // Only the terminator beat may carry a zero byte, and it always does.
    `PEB_ASSERT(a_term_zero, out_valid |-> ((out_byte == TERM_BYTE) == out_last), "bad terminator")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bounded percent encoder (percent_encoder_bounded).
// Holds its own model of the encoder, drives directed and random messages, and
// checks every output beat. Depends only on the RTL of the block.
module tb_top;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT     = 3000000;

    localparam logic [7:0]  PCT_CHAR     = 8'h25;
    localparam logic [7:0]  TERM_CHAR    = 8'h00;
    localparam logic [15:0] CAP_AT_RESET = 16'd32;
    localparam logic [15:0] CAP_MAX      = 16'hFFFF;
    localparam logic [7:0]  MARK_CHARS [4] = '{8'h2D, 8'h5F, 8'h2E, 8'h7E};

    // One output beat: encoded byte and terminator flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] out_capacity;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        out_last;

    // Encoded beats still owed by the block, oldest first.
    out_beat_t   pending_out_q[$];

    // Model of the encoder state and its capacity register.
    int unsigned cap_model;
    int unsigned written_model;
    bit          stopped_model;

    bit          burst_mode;
    int          items_sent;
    int          beats_checked;
    int          terminators_seen;
    int          cap_writes;
    int          mismatches;

    percent_encoder_bounded u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .out_capacity   (out_capacity),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last)
    );

    always #(CLK_HALF) clk = ~clk;

    // Letters, digits and the four unreserved marks pass through unchanged.
    function automatic bit is_plain(input logic [7:0] c);
        if (c >= "a" && c <= "z") return 1'b1;
        if (c >= "A" && c <= "Z") return 1'b1;
        if (c >= "0" && c <= "9") return 1'b1;
        return c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h7E;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        return 8'("A") + 8'(nib) - 8'd10;
    endfunction

    // Text byte for well-formed messages: mostly plain, some to be escaped.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        int         sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            case ($urandom_range(0, 3))
                0: b = 8'("a") + 8'($urandom_range(0, 25));
                1: b = 8'("A") + 8'($urandom_range(0, 25));
                2: b = 8'("0") + 8'($urandom_range(0, 9));
                default: b = MARK_CHARS[$urandom_range(0, 3)];
            endcase
        end
        else if (sel < 9) begin
            do b = 8'($urandom_range(1, 255)); while (is_plain(b));
        end
        else begin
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    // Work out the output beats that one accepted source beat must produce.
    task automatic encode_source_byte(input logic [7:0] c, input logic eom);
        bit          ends;
        bit          halt;
        int unsigned lim;
        ends = eom || c == 8'h00;
        halt = 1'b0;
        lim  = (cap_model == 0) ? 0 : cap_model - 1;
        if (stopped_model) begin
            if (ends) begin
                stopped_model = 1'b0;
                written_model = 0;
            end
            return;
        end
        if (c != 8'h00) begin
            if (written_model >= lim) begin
                halt = 1'b1;
            end
            else if (is_plain(c)) begin
                pending_out_q.push_back('{c, 1'b0});
                written_model++;
                halt = written_model >= lim;
            end
            else if (written_model + 3 < lim) begin
                pending_out_q.push_back('{PCT_CHAR, 1'b0});
                pending_out_q.push_back('{hex_char(c[7:4]), 1'b0});
                pending_out_q.push_back('{hex_char(c[3:0]), 1'b0});
                written_model += 3;
                halt = written_model >= lim;
            end
            else begin
                halt = 1'b1;
            end
        end
        if (ends || halt) begin
            pending_out_q.push_back('{TERM_CHAR, 1'b1});
            if (ends) begin
                written_model = 0;
                stopped_model = 1'b0;
            end
            else begin
                stopped_model = 1'b1;
            end
        end
    endtask

    // Send one source beat after a random gap (none in burst mode); returns at the next falling edge.
    task automatic send_beat(input logic [7:0] b, input logic eom);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        do @(posedge clk); while (in_stall !== 1'b0);
        encode_source_byte(b, eom);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending and let every owed beat drain, plus time for silent beats.
    task automatic drain_to_idle();
        in_valid <= 1'b0;
        while (pending_out_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        drain_to_idle();
        cfg_valid    <= 1'b1;
        out_capacity <= cap;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cap_model = cap;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input out_beat_t exp_beat,
                                   input out_beat_t got_beat);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, exp_beat.ch, exp_beat.last,
                     got_beat.ch, got_beat.last);
    endtask

    // Plain and escaped bytes at the default capacity, message closed by the flag.
    task automatic test_pass_and_escape();
        send_beat("z", 1'b0);
        send_beat("A", 1'b0);
        send_beat("0", 1'b0);
        send_beat("-", 1'b0);
        send_beat("~", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h2F, 1'b1);
    endtask

    // A zero byte ends the message by itself, with or without the flag.
    task automatic test_zero_byte();
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
    endtask

    // Buffer fills exactly; the block stays silent until the message end.
    task automatic test_buffer_full();
        write_capacity(16'd3);
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        send_beat("c", 1'b1);
    endtask

    // Second escape would not fit, so it is dropped and the terminator follows.
    task automatic test_escape_no_room();
        write_capacity(16'd5);
        send_beat(8'h20, 1'b0);
        send_beat(8'h3F, 1'b0);
        send_beat(8'h00, 1'b0);
    endtask

    // Capacity one and zero leave no room for any encoded byte.
    task automatic test_tiny_capacity();
        write_capacity(16'd1);
        send_beat("a", 1'b0);
        send_beat(8'h41, 1'b1);
        write_capacity(16'd0);
        send_beat(8'h7F, 1'b1);
    endtask

    // Capacity lowered to the written count while a message is open.
    task automatic test_capacity_lowered_mid_message();
        write_capacity(CAP_AT_RESET);
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        write_capacity(16'd2);
        send_beat("c", 1'b0);
        send_beat(8'h00, 1'b0);
    endtask

    task automatic test_max_capacity();
        write_capacity(CAP_MAX);
        send_beat(8'hFF, 1'b1);
    endtask

    // Phases of random capacity, each with a few messages, some left open.
    task automatic test_random_messages();
        int          stop_at;
        int          n_msgs;
        int          len;
        int          sel;
        logic [15:0] cap;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) cap = CAP_MAX;
            else if (sel == 1) cap = 16'($urandom_range(0, 1));
            else if (sel < 6) cap = 16'($urandom_range(2, 12));
            else cap = 16'($urandom_range(13, 64));
            write_capacity(cap);
            burst_mode = ($urandom_range(0, 3) == 0);
            n_msgs = $urandom_range(2, 6);
            for (int m = 0; m < n_msgs; m++) begin
                // Stop once the item budget is spent.
                if (items_sent >= stop_at) break;
                if ($urandom_range(0, 7) == 0) begin
                    // Noise: any byte, end flag now and then.
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                else begin
                    len = (cap == CAP_MAX) ? $urandom_range(1, 60) : $urandom_range(1, 24);
                    for (int i = 0; i < len - 1; i++)
                        send_beat(pick_text_byte(), 1'b0);
                    sel = $urandom_range(0, 7);
                    if (sel == 0)
                        send_beat(8'h00, 1'($urandom_range(0, 1)));
                    else if (sel == 1 && m == n_msgs - 1)
                        send_beat(pick_text_byte(), 1'b0);
                    else
                        send_beat(pick_text_byte(), 1'b1);
                end
            end
        end
        burst_mode = 1'b0;
    endtask

    // Output side: random stall before each beat (none in burst mode), then compare with the model.
    initial begin
        int        hold;
        out_beat_t got_beat;
        out_beat_t exp_beat;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = burst_mode ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got_beat = '{out_byte, out_last};
            beats_checked++;
            if (out_last === 1'b1) terminators_seen++;
            if (pending_out_q.size() == 0) begin
                report_mismatch("output beat with nothing pending", '0, got_beat);
            end
            else begin
                exp_beat = pending_out_q.pop_front();
                if (got_beat.ch !== exp_beat.ch || got_beat.last !== exp_beat.last)
                    report_mismatch("output beat differs", exp_beat, got_beat);
            end
            @(negedge clk);
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("Timeout with %0d output beats still pending.", pending_out_q.size());
        $display("FAIL percent_encoder_bounded");
        $finish;
    end

    initial begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        out_capacity   = CAP_AT_RESET;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        end_of_message = 1'b0;
        burst_mode     = 1'b0;
        cap_model      = CAP_AT_RESET;
        written_model  = 0;
        stopped_model  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pass_and_escape();
        test_zero_byte();
        test_buffer_full();
        test_escape_no_room();
        test_tiny_capacity();
        test_capacity_lowered_mid_message();
        test_max_capacity();
        test_random_messages();
        drain_to_idle();

        $display("Sent %0d source beats over %0d capacity writes; checked %0d output beats",
                 items_sent, cap_writes, beats_checked);
        $display("including %0d terminators, with %0d mismatches.",
                 terminators_seen, mismatches);
        if (mismatches == 0)
            $display("PASS percent_encoder_bounded");
        else
            $display("FAIL percent_encoder_bounded");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/pct_enc_pkg.sv
sv/pct_enc_front.sv
sv/pct_enc_queue.sv
sv/pct_enc_back.sv
sv/percent_encoder_bounded.sv
verif/tb_top.sv
